### rtl/bsfp_pkg.sv
`timescale 1ns / 1ps
package bsfp_pkg;

  // fifo geometry
  localparam int FifoDepth = 64;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int DataW     = 8;

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [DataW-1:0] word_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_SERVICE = 2'd2
  } req_e;

  // per-item request to one fifo
  typedef struct packed {
    logic  push;
    logic  pop;
    word_t data;
  } fifo_req_t;

  // per-item answer from one fifo
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
  } fifo_rsp_t;

endpackage

### rtl/bsfp_fifo.sv
`timescale 1ns / 1ps
module bsfp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsfp_pkg::fifo_req_t req_i,
  output bsfp_pkg::fifo_rsp_t rsp_o,
  output bsfp_pkg::word_t     rd_data_o
);

  bsfp_pkg::word_t mem [bsfp_pkg::FifoDepth];
  bsfp_pkg::word_t rd_q;
  bsfp_pkg::ptr_t  wptr_q, wptr_d;
  bsfp_pkg::ptr_t  rptr_q, rptr_d;
  bsfp_pkg::cnt_t  fill_q, fill_d;
  logic            push_ok, pop_ok;

  // full and empty checks on the current count
  assign push_ok = req_i.push && (fill_q != bsfp_pkg::cnt_t'(bsfp_pkg::FifoDepth));
  assign pop_ok  = req_i.pop && (fill_q != '0);

  assign rsp_o.push_ok = push_ok;
  assign rsp_o.pop_ok  = pop_ok;
  assign rd_data_o     = rd_q;

  // pointer wrap and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_ok) begin
      wptr_d = (wptr_q == bsfp_pkg::ptr_t'(bsfp_pkg::FifoDepth - 1)) ? '0
             : bsfp_pkg::ptr_t'(wptr_q + 1'b1);
    end
    if (pop_ok) begin
      rptr_d = (rptr_q == bsfp_pkg::ptr_t'(bsfp_pkg::FifoDepth - 1)) ? '0
             : bsfp_pkg::ptr_t'(rptr_q + 1'b1);
    end
    fill_d = fill_q + bsfp_pkg::cnt_t'(push_ok) - bsfp_pkg::cnt_t'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wptr_q] <= req_i.data;
    end
    if (pop_ok) begin
      rd_q <= mem[rptr_q];
    end
  end

endmodule

### rtl/buffered_serial_fifo_pair_top.sv
`timescale 1ns / 1ps
// a word accepted passes through the read stage, then the result register, before its result shows on the outputs
// throughput: one word per cycle unless the input is held off; each word does one registered read of the byte stores
// a stalled result holds the input off only while the read stage is also full
// reset: asynchronous, active low; clears pointers, counts, interrupt enable and valids
// byte stores are not cleared; an entry is only read after it was written
module buffered_serial_fifo_pair_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       rx_ready_i,
  input  logic       tx_empty_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic [7:0] read_byte_o,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       tx_irq_request_o
);

  bsfp_pkg::fifo_req_t tx_req, rx_req;
  bsfp_pkg::fifo_rsp_t tx_rsp, rx_rsp;
  bsfp_pkg::word_t     tx_rd, rx_rd;

  logic in_acc, out_free;
  logic irq_q, irq_d;
  logic pend_q, pend_d;
  logic pend_acc_q, pend_rd_q, pend_snd_q, pend_irq_q;
  logic out_valid_q, out_valid_d;
  logic out_acc_q, out_snd_q, out_irq_q;
  bsfp_pkg::word_t out_rd_q, out_sb_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // request decode into fifo operations and interrupt enable
  always_comb begin
    tx_req      = '0;
    rx_req      = '0;
    tx_req.data = data_byte_i;
    rx_req.data = data_byte_i;
    irq_d       = irq_q;
    if (in_acc) begin
      unique case (bsfp_pkg::req_e'(req_type_i))
        bsfp_pkg::REQ_WRITE: begin
          tx_req.push = 1'b1;
          irq_d       = 1'b1;
        end
        bsfp_pkg::REQ_READ: begin
          rx_req.pop = 1'b1;
        end
        bsfp_pkg::REQ_SERVICE: begin
          rx_req.push = rx_ready_i;
          tx_req.pop  = tx_empty_i;
          if (tx_empty_i && !tx_rsp.pop_ok) begin
            irq_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  bsfp_fifo u_tx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tx_req),
    .rsp_o    (tx_rsp),
    .rd_data_o(tx_rd)
  );

  bsfp_fifo u_rx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (rx_req),
    .rsp_o    (rx_rsp),
    .rd_data_o(rx_rd)
  );

  // read stage and output register occupancy
  always_comb begin
    if (in_acc) begin
      pend_d = 1'b1;
    end else if (out_free) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
    out_valid_d = out_free ? pend_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      irq_q       <= irq_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // flags of the word waiting for its read data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_acc_q <= tx_rsp.push_ok || rx_rsp.pop_ok;
      pend_rd_q  <= rx_rsp.pop_ok;
      pend_snd_q <= tx_rsp.pop_ok;
      pend_irq_q <= irq_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_free && pend_q) begin
      out_acc_q <= pend_acc_q;
      out_rd_q  <= pend_rd_q ? rx_rd : '0;
      out_snd_q <= pend_snd_q;
      out_sb_q  <= pend_snd_q ? tx_rd : '0;
      out_irq_q <= pend_irq_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign read_byte_o      = out_rd_q;
  assign send_valid_o     = out_snd_q;
  assign send_byte_o      = out_sb_q;
  assign tx_irq_request_o = out_irq_q;

endmodule

### rtl/bsfp_checker.sv
`timescale 1ns / 1ps
module bsfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accepted_o,
  input logic [7:0] read_byte_o,
  input logic       send_valid_o,
  input logic [7:0] send_byte_o,
  input logic       tx_irq_request_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_byte_o)
      && $stable(send_byte_o) && $stable(accepted_o))
    else $error("stalled result word changed");

  // input is held off only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // a popped send byte comes from a service word with the interrupt still enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> !accepted_o && read_byte_o == 8'd0 && tx_irq_request_o)
    else $error("send word inconsistent");

  // an unused send byte reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> send_byte_o == 8'd0)
    else $error("send byte not zero");

endmodule

bind buffered_serial_fifo_pair_top bsfp_checker u_bsfp_checker (.*);

### sim/tb_buffered_serial_fifo_pair_top.sv
`timescale 1ns / 1ps
module tb_buffered_serial_fifo_pair_top;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int         NumWords  = 1350;
  localparam int         MaxCycles = 300000;

  // one request word as the driver presents it
  typedef struct {
    logic [1:0]      req;
    bsfp_pkg::word_t data;
    logic            rx_rdy;
    logic            tx_emp;
    bit              drain;
  } req_word_t;

  // one result word as the block returns it
  typedef struct packed {
    logic            accepted;
    bsfp_pkg::word_t read_byte;
    logic            send_valid;
    bsfp_pkg::word_t send_byte;
    logic            tx_irq;
  } result_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [1:0] req_type_i       = 2'd0;
  logic [7:0] data_byte_i      = 8'd0;
  logic       rx_ready_i       = 1'b0;
  logic       tx_empty_i       = 1'b0;
  logic       out_stall_i      = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       accepted_o;
  logic [7:0] read_byte_o;
  logic       send_valid_o;
  logic [7:0] send_byte_o;
  logic       tx_irq_request_o;

  buffered_serial_fifo_pair_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .rx_ready_i       (rx_ready_i),
    .tx_empty_i       (tx_empty_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .read_byte_o      (read_byte_o),
    .send_valid_o     (send_valid_o),
    .send_byte_o      (send_byte_o),
    .tx_irq_request_o (tx_irq_request_o)
  );

  req_word_t pending_q[$];
  result_t   expected_q[$];

  // mirror of the two fifos and the interrupt enable
  bsfp_pkg::word_t tx_mem [bsfp_pkg::FifoDepth];
  bsfp_pkg::word_t rx_mem [bsfp_pkg::FifoDepth];
  bsfp_pkg::ptr_t  tx_wr = '0, tx_rd = '0, rx_wr = '0, rx_rd = '0;
  bsfp_pkg::cnt_t  tx_cnt = '0, rx_cnt = '0;
  logic            irq_en = 1'b0;

  int err_cnt = 0, words_in = 0, results_seen = 0, planned_words = 0, cycle_cnt = 0;
  int tx_drops = 0, rx_drops = 0, empty_reads = 0, irq_clears = 0, ignored = 0;

  // handshake and idling state
  bit word_taken = 1'b0;
  int burst_left = 1, gap_left = 0;
  int stall_mode = 0, stall_left = 0;

  function automatic bsfp_pkg::ptr_t next_pos(bsfp_pkg::ptr_t p);
    return (p == bsfp_pkg::ptr_t'(bsfp_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // apply one request to the mirrored fifos, return the result it gives
  function automatic result_t serve_request(logic [1:0] req, bsfp_pkg::word_t data,
                                            logic rx_rdy, logic tx_emp);
    result_t res;
    res = '0;
    case (req)
      bsfp_pkg::REQ_WRITE: begin
        if (tx_cnt < bsfp_pkg::FifoDepth) begin
          tx_mem[tx_wr] = data;
          tx_wr = next_pos(tx_wr);
          tx_cnt++;
          res.accepted = 1'b1;
        end else begin
          tx_drops++;
        end
        irq_en = 1'b1;
      end
      bsfp_pkg::REQ_READ: begin
        if (rx_cnt != 0) begin
          res.accepted  = 1'b1;
          res.read_byte = rx_mem[rx_rd];
          rx_rd = next_pos(rx_rd);
          rx_cnt--;
        end else begin
          empty_reads++;
        end
      end
      bsfp_pkg::REQ_SERVICE: begin
        // received byte first, silently lost when rx is full
        if (rx_rdy) begin
          if (rx_cnt < bsfp_pkg::FifoDepth) begin
            rx_mem[rx_wr] = data;
            rx_wr = next_pos(rx_wr);
            rx_cnt++;
          end else begin
            rx_drops++;
          end
        end
        // then feed the transmitter or drop the interrupt enable
        if (tx_emp) begin
          if (tx_cnt != 0) begin
            res.send_valid = 1'b1;
            res.send_byte  = tx_mem[tx_rd];
            tx_rd = next_pos(tx_rd);
            tx_cnt--;
          end else begin
            irq_en = 1'b0;
            irq_clears++;
          end
        end
      end
      default: ignored++;
    endcase
    res.tx_irq = irq_en;
    return res;
  endfunction

  function automatic void add_word(logic [1:0] req, bsfp_pkg::word_t data, logic rx_rdy,
                                   logic tx_emp, bit drain);
    req_word_t w;
    w.req    = req;
    w.data   = data;
    w.rx_rdy = rx_rdy;
    w.tx_emp = tx_emp;
    w.drain  = drain;
    pending_q.push_back(w);
    if (req != ReqUnused) planned_words++;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 50) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string field, int got_v, int want_v);
    if (got_v != want_v)
      report_mismatch($sformatf("result %0d: %s got 0x%0h expected 0x%0h",
                                results_seen, field, got_v, want_v));
  endtask

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver: bursts of words with random gaps, holds a word while stalled
  always @(negedge clk_i) begin
    req_word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // word still waiting, keep it steady
    end else if (gap_left > 0) begin
      gap_left   <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (pending_q.size() == 0 || (pending_q[0].drain && expected_q.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt = pending_q.pop_front();
      req_type_i  <= nxt.req;
      data_byte_i <= nxt.data;
      rx_ready_i  <= nxt.rx_rdy;
      tx_empty_i  <= nxt.tx_emp;
      in_valid_i  <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall: switches between a few patterns every so often
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ((cycle_cnt % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // monitor: check the result word, then predict for the accepted request word
  always @(posedge clk_i) begin
    result_t got, want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{accepted_o, read_byte_o, send_valid_o, send_byte_o, tx_irq_request_o};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%0h with nothing expected", got));
        end else begin
          want = expected_q.pop_front();
          check_field("accepted", int'(got.accepted), int'(want.accepted));
          check_field("read_byte", int'(got.read_byte), int'(want.read_byte));
          check_field("send_valid", int'(got.send_valid), int'(want.send_valid));
          check_field("send_byte", int'(got.send_byte), int'(want.send_byte));
          check_field("tx_irq_request", int'(got.tx_irq), int'(want.tx_irq));
        end
        results_seen++;
      end
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(serve_request(req_type_i, data_byte_i, rx_ready_i, tx_empty_i));
        words_in++;
      end
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    int  i, n, m, kind;
    bit  first_seq;
    bit  drain_next;

    // directed: empty fifos, extremes, ignored and unused fields
    add_word(bsfp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_WRITE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_word(ReqUnused, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'hA5, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h5A, 1'b1, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'hFF, 1'b0, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_READ, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_WRITE, 8'h80, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h01, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_WRITE, 8'h7F, 1'b0, 1'b1, 1'b0);
    add_word(ReqUnused, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h00, 1'b1, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_SERVICE, 8'h00, 1'b0, 1'b1, 1'b0);
    add_word(bsfp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    add_word(bsfp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0);

    // random: fill and drain runs, mixed traffic, a little noise
    first_seq = 1'b1;
    while (planned_words < NumWords) begin
      kind       = $urandom_range(0, 9);
      drain_next = first_seq || ($urandom_range(0, 7) == 0);
      first_seq  = 1'b0;
      if (kind <= 2) begin
        // tx burst, often past full, then the port drains it
        n = $urandom_range(8, 80);
        for (i = 0; i < n; i++)
          add_word(bsfp_pkg::REQ_WRITE, bsfp_pkg::word_t'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   drain_next && i == 0);
        m = $urandom_range(n / 2, n + 6);
        for (i = 0; i < m; i++)
          add_word(bsfp_pkg::REQ_SERVICE, bsfp_pkg::word_t'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0, 1'b0);
      end else if (kind <= 5) begin
        // port fills rx, often past full, then the processor reads it out
        n = $urandom_range(8, 80);
        for (i = 0; i < n; i++)
          add_word(bsfp_pkg::REQ_SERVICE, bsfp_pkg::word_t'($urandom_range(0, 255)),
                   $urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)),
                   drain_next && i == 0);
        m = $urandom_range(n / 2, n + 6);
        for (i = 0; i < m; i++)
          add_word(bsfp_pkg::REQ_READ, bsfp_pkg::word_t'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      end else if (kind <= 8) begin
        n = $urandom_range(10, 40);
        for (i = 0; i < n; i++)
          add_word(2'($urandom_range(bsfp_pkg::REQ_WRITE, bsfp_pkg::REQ_SERVICE)),
                   bsfp_pkg::word_t'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   drain_next && i == 0);
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          add_word(2'($urandom_range(bsfp_pkg::REQ_WRITE, ReqUnused)),
                   bsfp_pkg::word_t'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d request words and %0d results; full drops: %0d tx, %0d rx",
             words_in, results_seen, tx_drops, rx_drops);
    $display("empty rx reads: %0d, interrupt clears on idle tx: %0d, ignored requests: %0d",
             empty_reads, irq_clears, ignored);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### buffered_serial_fifo_pair_top.f
rtl/bsfp_pkg.sv
rtl/bsfp_fifo.sv
rtl/buffered_serial_fifo_pair_top.sv
rtl/bsfp_checker.sv
sim/tb_buffered_serial_fifo_pair_top.sv
